// ===== design/modbus_rtu_slave_frame_handler_top_defines.svh =====
// Assertion macros shared by the Modbus RTU frame handler.
`ifndef MODBUS_RTU_SLAVE_FRAME_HANDLER_TOP_DEFINES_SVH
`define MODBUS_RTU_SLAVE_FRAME_HANDLER_TOP_DEFINES_SVH
// Property a implies b at the same edge, checked out of reset.
`define MRS_ASSERT_IMP(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
// Property a implies b at the next edge.
`define MRS_ASSERT_NXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`endif

// ===== design/mrs_pkg.sv =====
// Package with codes and helpers for the Modbus RTU frame handler.
`default_nettype none
package mrs_pkg;
  localparam int READ_REGS_DEF   = 16;
  localparam int WRITE_REGS_DEF  = 16;
  localparam int FRAME_BYTES_DEF = 64;

  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_EOF  = 2'd1;
  localparam logic [1:0] KIND_SET  = 2'd2;
  localparam logic [1:0] KIND_GET  = 2'd3;

  localparam logic [7:0] FN_READ   = 8'h03;
  localparam logic [7:0] FN_WRITE1 = 8'h06;
  localparam logic [7:0] FN_WRITEN = 8'h10;
  localparam logic [7:0] EXC_FLAG  = 8'h80;
  localparam logic [7:0] EXC_FUNC  = 8'h01;
  localparam logic [7:0] EXC_ADDR  = 8'h02;
  localparam logic [7:0] EXC_DATA  = 8'h03;

  localparam logic [1:0] REG_SLAVE = 2'd0;
  localparam logic [1:0] REG_RBASE = 2'd1;
  localparam logic [1:0] REG_WBASE = 2'd2;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // One shift step of the reflected CRC-16.
  function automatic logic [15:0] crc_bit(input logic [15:0] c);
    crc_bit = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
  endfunction

  // Index mod 10: command index of a multiple write; a single write drives the motor for index mod 10 below 5.
  function automatic logic [3:0] mod10(input logic [4:0] v);
    mod10 = (v >= 5'd20) ? 4'(v - 5'd20) : (v >= 5'd10) ? 4'(v - 5'd10) : v[3:0];
  endfunction
endpackage
`default_nettype wire

// ===== design/modbus_rtu_slave_frame_handler_top.sv =====
// Modbus RTU slave frame handler: frame buffer, CRC unit, server sequencer.
//
// Input channel in_*: kind 0 delivers one received byte, kind 1 marks end of
// frame, kind 2 sets a read-table entry, kind 3 reads a holding register.
// Output channel out_*: response bytes (out_tlast on the final byte) or one
// holding value beat for a kind 3 request.
// An accepted byte that fits in the buffer goes through 8 CRC shift steps.
// End of frame loads and decodes the header (a dropped frame ends once its
// address, length and overrun flag are checked), then a multiple write copies
// its data words; each response byte before the CRC waits for the table read,
// is loaded, goes through 8 CRC steps and is output, and each CRC byte skips
// the CRC steps. Kind 2 is written when accepted; kind 3 goes to the output.
// One item at a time: in_tready is low while an item is worked on.
// Results pass through a one-beat output register; a stalled receiver holds
// the sequencer at that register with no loss.
// Reset clears the counters, CRC and both register tables at once (the
// tables have valid bits), and the configuration returns to address 1, bases
// 0. The configuration port is an APB slave with pready always high.
`default_nettype none
`include "modbus_rtu_slave_frame_handler_top_defines.svh"
module modbus_rtu_slave_frame_handler_top
  import mrs_pkg::*;
#(
  parameter int READ_REGS   = READ_REGS_DEF,
  parameter int WRITE_REGS  = WRITE_REGS_DEF,
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  // tdata: rx_byte[7:0], reg_index[11:8], reg_value[27:12], zeros[31:28]
  input  wire  [31:0] in_tdata,
  // tuser: kind[1:0]
  input  wire  [1:0]  in_tuser,
  output logic        out_tvalid,
  input  wire         out_tready,
  // tdata: tx_byte[7:0], app_value[23:8], motor_command[24], load_command[25],
  // command_index[29:26], zeros[31:30]
  output logic [31:0] out_tdata,
  // tuser: result_kind
  output logic        out_tuser,
  output logic        out_tlast,
  input  wire         cfg_psel,
  input  wire         cfg_penable,
  input  wire         cfg_pwrite,
  input  wire  [3:0]  cfg_paddr,
  input  wire  [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  localparam int FBW = $clog2(FRAME_BYTES);
  localparam int CW  = $clog2(FRAME_BYTES + 1);

  // Sequencer states.
  localparam logic [4:0] S_IDLE = 5'd0,  S_CRC  = 5'd1,  S_EOF  = 5'd2,
                         S_HDR  = 5'd3,  S_DEC  = 5'd4,
                         S_WRN  = 5'd9,  S_EMIT = 5'd10, S_ECRC = 5'd11,
                         S_OUT  = 5'd12, S_GET  = 5'd13,
                         S_ERD  = 5'd15;

  logic [7:0]  slave_r;
  logic [15:0] rbase_r, wbase_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite;
  always_comb begin
    case (cfg_paddr[3:2])
      REG_SLAVE: cfg_prdata = {24'd0, slave_r};
      REG_RBASE: cfg_prdata = {16'd0, rbase_r};
      REG_WBASE: cfg_prdata = {16'd0, wbase_r};
      default:   cfg_prdata = 32'd0;
    endcase
  end

  logic [4:0]  st_r;
  logic [3:0]  bit_r;
  logic [15:0] crc_r;
  logic [CW-1:0] cnt_r;
  logic        ovr_r;
  logic [7:0]  fbuf [FRAME_BYTES];
  logic [FBW-1:0] fb_wa;
  logic [FBW-1:0] fb_ra_r;
  logic [7:0]  fb_q_r;
  logic        fb_we;

  logic [15:0] rtab [16];
  logic [15:0] htab [16];
  logic [15:0] rvld_r, hvld_r;
  logic [15:0] rq_r, hq_r;

  // Response registers.
  logic [7:0]  func_r, b2_r, b3_r;
  logic [15:0] start_r, qty_r;
  logic [5:0]  rlen_r;   // payload bytes before CRC
  logic [5:0]  ridx_r;   // byte being emitted
  logic [15:0] tcrc_r;
  logic [7:0]  exc_r;
  logic        isexc_r, motor_r, load_r;
  logic [3:0]  cidx_r;
  logic [3:0]  tidx_r;
  logic [3:0]  gidx_r;
  logic [4:0]  wcnt_r;
  logic [7:0]  hi_r;
  logic [7:0]  cur_r;

  logic [7:0] in_byte;
  logic [3:0] in_idx;
  logic [15:0] in_val;
  assign in_byte = in_tdata[7:0];
  assign in_idx  = in_tdata[11:8];
  assign in_val  = in_tdata[27:12];

  logic        o_v_r, o_last_r, o_kind_r, o_m_r, o_l_r;
  logic [7:0]  o_b_r;
  logic [15:0] o_a_r;
  logic [3:0]  o_c_r;
  assign out_tvalid = o_v_r;
  assign out_tuser  = o_kind_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = {2'b00, o_c_r, o_l_r, o_m_r, o_a_r, o_b_r};

  assign in_tready = (st_r == S_IDLE);
  logic acc;
  assign acc = in_tvalid & in_tready;

  assign fb_we = acc && in_tuser == KIND_BYTE && !ovr_r && cnt_r < CW'(FRAME_BYTES);
  assign fb_wa = cnt_r[FBW-1:0];
  always_ff @(posedge clk) begin
    if (fb_we) fbuf[fb_wa] <= in_byte;
    fb_q_r <= fbuf[fb_ra_r];
  end

  // Table ports: the read table is written by an accepted kind 2 item, the holding table by the sequencer.
  logic        rt_we, ht_we;
  logic [3:0]  rt_wa, ht_wa, rt_ra, ht_ra;
  logic [15:0] ht_wd;
  always_ff @(posedge clk) begin
    if (rt_we) rtab[rt_wa] <= in_val;
    if (ht_we) htab[ht_wa] <= ht_wd;
    rq_r <= rvld_r[rt_ra] ? rtab[rt_ra] : 16'd0;
    hq_r <= hvld_r[ht_ra] ? htab[ht_ra] : 16'd0;
  end
  assign rt_we = acc && in_tuser == KIND_SET && 32'(in_idx) < READ_REGS;
  assign rt_wa = in_idx;
  assign rt_ra = tidx_r;
  // The input beat may change after it is accepted, so the held index is used later.
  assign ht_ra = (st_r == S_IDLE) ? in_idx : gidx_r;

  // Derived response byte at position ridx_r.
  logic [7:0] rbyte;
  always_comb begin
    rbyte = 8'd0;
    if (isexc_r) begin
      case (ridx_r)
        6'd0: rbyte = slave_r;
        6'd1: rbyte = func_r | EXC_FLAG;
        default: rbyte = exc_r;
      endcase
    end else if (func_r == FN_READ) begin
      case (ridx_r)
        6'd0: rbyte = slave_r;
        6'd1: rbyte = FN_READ;
        6'd2: rbyte = {qty_r[6:0], 1'b0};
        default: rbyte = ridx_r[0] ? rq_r[15:8] : rq_r[7:0];
      endcase
    end else begin
      case (ridx_r)
        6'd0: rbyte = slave_r;
        6'd1: rbyte = func_r;
        6'd2: rbyte = b2_r;
        6'd3: rbyte = b3_r;
        6'd4: rbyte = qty_r[15:8];
        default: rbyte = qty_r[7:0];
      endcase
    end
  end

  logic [16:0] roff, woff;
  logic [17:0] rend, wend;
  assign roff = {1'b0, start_r} - {1'b0, rbase_r};
  assign woff = {1'b0, start_r} - {1'b0, wbase_r};
  assign rend = {1'b0, roff} + {2'b0, qty_r};
  assign wend = {1'b0, woff} + {2'b0, qty_r};

  logic [3:0] rd_phase_r;  // sub-step inside header/data loads

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; cnt_r <= '0; ovr_r <= 1'b0; crc_r <= CRC_INIT;
      slave_r <= 8'd1; rbase_r <= 16'd0; wbase_r <= 16'd0;
      rvld_r <= '0; hvld_r <= '0; o_v_r <= 1'b0; ht_we <= 1'b0;
      bit_r <= '0; rd_phase_r <= '0;
    end else begin
      ht_we <= 1'b0;
      if (cfg_wr) begin
        case (cfg_paddr[3:2])
          REG_SLAVE: slave_r <= cfg_pwdata[7:0];
          REG_RBASE: rbase_r <= cfg_pwdata[15:0];
          REG_WBASE: wbase_r <= cfg_pwdata[15:0];
          default: ;
        endcase
      end
      if (out_tready) o_v_r <= 1'b0;
      if (rt_we) rvld_r[in_idx] <= 1'b1;
      case (st_r)
        S_IDLE: if (acc) begin
          case (in_tuser)
            KIND_BYTE: begin
              if (fb_we) begin
                cnt_r <= cnt_r + 1'b1; crc_r <= crc_r ^ {8'd0, in_byte};
                bit_r <= 4'd0; st_r <= S_CRC;
              end else ovr_r <= 1'b1;
            end
            KIND_EOF: begin
              fb_ra_r <= '0; rd_phase_r <= '0; st_r <= S_EOF;
            end
            KIND_GET: begin
              gidx_r <= in_idx; st_r <= S_GET;
            end
            default: ;
          endcase
        end
        S_CRC: begin
          crc_r <= crc_bit(crc_r); bit_r <= bit_r + 1'b1;
          if (bit_r == 4'd7) st_r <= S_IDLE;
        end
        S_GET: if (!o_v_r || out_tready) begin
          o_v_r <= 1'b1; o_kind_r <= 1'b1; o_b_r <= 8'd0; o_last_r <= 1'b0;
          o_a_r <= (32'(gidx_r) < WRITE_REGS) ? hq_r : 16'd0;
          o_m_r <= 1'b0; o_l_r <= 1'b0; o_c_r <= 4'd0; st_r <= S_IDLE;
        end
        S_EOF: begin
          // Load header bytes 0..5 one per cycle (registered read).
          fb_ra_r <= fb_ra_r + 1'b1; rd_phase_r <= rd_phase_r + 1'b1;
          case (rd_phase_r)
            4'd2: func_r <= fb_q_r;
            4'd3: b2_r <= fb_q_r;
            4'd4: b3_r <= fb_q_r;
            4'd5: qty_r[15:8] <= fb_q_r;
            4'd6: qty_r[7:0] <= fb_q_r;
            default: ;
          endcase
          if (rd_phase_r == 4'd1) begin
            if (ovr_r || cnt_r < CW'(8) || fb_q_r != slave_r) st_r <= S_HDR;
          end
          if (rd_phase_r == 4'd6) begin
            start_r <= {b2_r, b3_r}; st_r <= S_DEC;
          end
        end
        S_HDR: begin
          // Drop the frame silently.
          cnt_r <= '0; ovr_r <= 1'b0; crc_r <= CRC_INIT; st_r <= S_IDLE;
        end
        S_DEC: begin
          isexc_r <= 1'b0; motor_r <= 1'b0; load_r <= 1'b0; cidx_r <= 4'd0;
          st_r <= S_EMIT; ridx_r <= '0; tcrc_r <= CRC_INIT;
          if (crc_r != 16'd0) begin
            isexc_r <= 1'b1; exc_r <= EXC_DATA; rlen_r <= 6'd3;
          end else if (func_r == FN_READ) begin
            if (start_r < rbase_r || rend > 18'(READ_REGS)) begin
              isexc_r <= 1'b1; exc_r <= EXC_ADDR; rlen_r <= 6'd3;
            end else begin
              rlen_r <= 6'(3 + 2 * qty_r[4:0]); tidx_r <= roff[3:0];
            end
          end else if (func_r == FN_WRITE1) begin
            if (start_r < wbase_r || woff >= 17'(WRITE_REGS)) begin
              isexc_r <= 1'b1; exc_r <= EXC_ADDR; rlen_r <= 6'd3;
            end else begin
              ht_we <= 1'b1; ht_wa <= woff[3:0]; ht_wd <= qty_r;
              hvld_r[woff[3:0]] <= 1'b1;
              motor_r <= mod10({1'b0, woff[3:0]}) < 4'd5;
              load_r <= !(mod10({1'b0, woff[3:0]}) < 4'd5);
              cidx_r <= woff[3:0]; rlen_r <= 6'd6;
              if (cnt_r != CW'(8)) begin
                isexc_r <= 1'b1; exc_r <= EXC_DATA; rlen_r <= 6'd3;
              end
            end
          end else if (func_r == FN_WRITEN) begin
            if (start_r < wbase_r || wend > 18'(WRITE_REGS)) begin
              isexc_r <= 1'b1; exc_r <= EXC_ADDR; rlen_r <= 6'd3;
            end else if ({{(18-CW){1'b0}}, cnt_r} < 18'd9 + {1'b0, qty_r, 1'b0}) begin
              isexc_r <= 1'b1; exc_r <= EXC_DATA; rlen_r <= 6'd3;
            end else begin
              motor_r <= 1'b1; cidx_r <= mod10({1'b0, woff[3:0]});
              rlen_r <= 6'd6; tidx_r <= woff[3:0]; wcnt_r <= '0;
              fb_ra_r <= FBW'(7); rd_phase_r <= '0;
              st_r <= S_WRN;
            end
          end else begin
            isexc_r <= 1'b1; exc_r <= EXC_FUNC; rlen_r <= 6'd3;
          end
        end
        S_WRN: begin
          // Copy data words: hold the high byte read, then write the word with the low byte read.
          if (5'(wcnt_r) == qty_r[4:0] && rd_phase_r == 4'd0) begin
            st_r <= S_EMIT;
          end else begin
            rd_phase_r <= rd_phase_r + 1'b1;
            case (rd_phase_r)
              4'd0: fb_ra_r <= fb_ra_r + 1'b1;
              4'd1: begin hi_r <= fb_q_r; fb_ra_r <= fb_ra_r + 1'b1; end
              default: begin
                ht_we <= 1'b1; ht_wa <= tidx_r; ht_wd <= {hi_r, fb_q_r};
                hvld_r[tidx_r] <= 1'b1; tidx_r <= tidx_r + 1'b1;
                wcnt_r <= wcnt_r + 1'b1; rd_phase_r <= '0;
              end
            endcase
          end
        end
        S_EMIT: begin
          // Wait state so the registered read-table data matches ridx_r.
          st_r <= S_ERD;
        end
        S_ERD: begin
          if (ridx_r < rlen_r) begin
            cur_r <= rbyte; tcrc_r <= tcrc_r ^ {8'd0, rbyte};
          end else cur_r <= (ridx_r == rlen_r) ? tcrc_r[7:0] : tcrc_r[15:8];
          bit_r <= 4'd0;
          st_r <= (ridx_r < rlen_r) ? S_ECRC : S_OUT;
        end
        S_ECRC: begin
          tcrc_r <= crc_bit(tcrc_r); bit_r <= bit_r + 1'b1;
          if (bit_r == 4'd7) st_r <= S_OUT;
        end
        S_OUT: if (!o_v_r || out_tready) begin
          o_v_r <= 1'b1; o_kind_r <= 1'b0; o_b_r <= cur_r; o_a_r <= 16'd0;
          o_last_r <= (ridx_r == rlen_r + 6'd1);
          o_m_r <= (ridx_r == rlen_r + 6'd1) & motor_r;
          o_l_r <= (ridx_r == rlen_r + 6'd1) & load_r;
          o_c_r <= (ridx_r == rlen_r + 6'd1) ? cidx_r : 4'd0;
          if (ridx_r == rlen_r + 6'd1) begin
            cnt_r <= '0; ovr_r <= 1'b0; crc_r <= CRC_INIT; st_r <= S_IDLE;
          end else begin
            ridx_r <= ridx_r + 1'b1;
            if (func_r == FN_READ && !isexc_r && ridx_r >= 6'd3 && !ridx_r[0])
              tidx_r <= tidx_r + 1'b1;
            st_r <= S_EMIT;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  `MRS_ASSERT_IMP(a_busy_notready, clk, rst_n, st_r != S_IDLE, !in_tready)
  `MRS_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CW'(FRAME_BYTES))
  `MRS_ASSERT_NXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
endmodule
`default_nettype wire

// ===== tb/modbus_rtu_slave_frame_handler_top_test.sv =====
// Self-checking testbench for the Modbus RTU slave frame handler.
`timescale 1ns / 1ps
module modbus_rtu_slave_frame_handler_top_test;
  import mrs_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 600;
  localparam int PHASE_ITEMS  = 55;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  tx_byte;
    logic        tx_last;
    logic [15:0] app_value;
    logic        motor_command;
    logic        load_command;
    logic [3:0]  command_index;
  } resp_beat_t;

  typedef struct {
    logic [1:0]  kind;
    logic [7:0]  rx_byte;
    logic [3:0]  reg_index;
    logic [15:0] reg_value;
    bit          seal_crc;
    bit          known;
    logic [15:0] known_value;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  modbus_rtu_slave_frame_handler_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #6 clk = ~clk;

  // Predictor state.
  logic [7:0]  own_addr;
  logic [15:0] rd_base;
  logic [15:0] wr_base;
  logic [7:0]  rx_buf [64];
  int          rx_count;
  bit          rx_overrun;
  logic [15:0] rx_crc;
  logic [15:0] read_regs [16];
  logic [15:0] hold_regs [16];
  logic [7:0]  reply [40];

  resp_beat_t  pending_beats [$];
  logic [7:0]  frame_bytes [$];
  int          errors = 0;
  int          items_sent = 0;
  int          beats_seen = 0;
  int          replies_seen = 0;
  int          cycles = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;

  function automatic logic [15:0] crc16_update(logic [15:0] c, logic [7:0] b);
    c = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    return c;
  endfunction

  // Appends the CRC to the reply and queues it one beat per byte.
  function automatic void queue_reply(int len, bit motor, bit load, int cidx);
    logic [15:0] c;
    resp_beat_t  bt;
    c = 16'hFFFF;
    for (int i = 0; i < len; i++) c = crc16_update(c, reply[i]);
    reply[len] = c[7:0];
    reply[len + 1] = c[15:8];
    for (int i = 0; i < len + 2; i++) begin
      bt = '0;
      bt.tx_byte = reply[i];
      if (i == len + 1) begin
        bt.tx_last = 1'b1;
        bt.motor_command = motor;
        bt.load_command = load;
        bt.command_index = (motor || load) ? cidx[3:0] : 4'd0;
      end
      pending_beats.push_back(bt);
    end
  endfunction

  function automatic void queue_exception(logic [7:0] func, logic [7:0] code, bit motor,
                                          bit load, int cidx);
    reply[0] = own_addr;
    reply[1] = func | EXC_FLAG;
    reply[2] = code;
    queue_reply(3, motor, load, cidx);
  endfunction

  function automatic void serve_request();
    logic [7:0] func;
    int start, qty, idx;
    bit motor;
    if (rx_overrun || rx_count < 8 || rx_buf[0] != own_addr) return;
    func = rx_buf[1];
    if (rx_crc != 16'h0000) begin
      queue_exception(func, EXC_DATA, 0, 0, 0);
      return;
    end
    start = {rx_buf[2], rx_buf[3]};
    qty = {rx_buf[4], rx_buf[5]};
    case (func)
      FN_READ: begin
        if (start < rd_base || (start - rd_base) + qty > 16) begin
          queue_exception(func, EXC_ADDR, 0, 0, 0);
          return;
        end
        idx = start - rd_base;
        reply[0] = own_addr;
        reply[1] = FN_READ;
        reply[2] = 8'(qty * 2);
        for (int i = 0; i < qty; i++) begin
          reply[3 + i * 2] = read_regs[(idx + i) & 15][15:8];
          reply[4 + i * 2] = read_regs[(idx + i) & 15][7:0];
        end
        queue_reply(3 + qty * 2, 0, 0, 0);
      end
      FN_WRITE1: begin
        if (start < wr_base || (start - wr_base) >= 16) begin
          queue_exception(func, EXC_ADDR, 0, 0, 0);
          return;
        end
        idx = start - wr_base;
        hold_regs[idx & 15] = 16'(qty);
        motor = (idx % 10) < 5;
        if (rx_count != 8) begin
          queue_exception(func, EXC_DATA, motor, !motor, idx);
          return;
        end
        for (int i = 0; i < 6; i++) reply[i] = rx_buf[i];
        reply[0] = own_addr;
        queue_reply(6, motor, !motor, idx);
      end
      FN_WRITEN: begin
        if (start < wr_base || (start - wr_base) + qty > 16) begin
          queue_exception(func, EXC_ADDR, 0, 0, 0);
          return;
        end
        idx = start - wr_base;
        if (rx_count < 9 + qty * 2) begin
          queue_exception(func, EXC_DATA, 0, 0, 0);
          return;
        end
        for (int i = 0; i < qty; i++)
          hold_regs[(idx + i) & 15] = {rx_buf[7 + i * 2], rx_buf[8 + i * 2]};
        for (int i = 0; i < 6; i++) reply[i] = rx_buf[i];
        reply[0] = own_addr;
        queue_reply(6, 1, 0, idx % 10);
      end
      default: queue_exception(func, EXC_FUNC, 0, 0, 0);
    endcase
  endfunction

  function automatic void predict_item(logic [1:0] kind, logic [7:0] b, logic [3:0] ri,
                                       logic [15:0] rv);
    resp_beat_t bt;
    case (kind)
      KIND_BYTE: begin
        if (rx_overrun || rx_count >= 64) rx_overrun = 1'b1;
        else begin
          rx_buf[rx_count] = b;
          rx_count++;
          rx_crc = crc16_update(rx_crc, b);
        end
      end
      KIND_EOF: begin
        serve_request();
        rx_count = 0;
        rx_overrun = 1'b0;
        rx_crc = 16'hFFFF;
      end
      KIND_SET: read_regs[ri] = rv;
      default: begin
        bt = '0;
        bt.result_kind = 1'b1;
        bt.app_value = hold_regs[ri];
        pending_beats.push_back(bt);
      end
    endcase
  endfunction

  // One beat on the input channel; valid stays high across back-to-back items.
  task automatic send_item(logic [1:0] kind, logic [7:0] b, logic [3:0] ri,
                           logic [15:0] rv);
    if ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {4'h0, rv, ri, b};
    do @(posedge clk); while (!in_tready);
    predict_item(kind, b, ri, rv);
    items_sent++;
  endtask

  task automatic send_byte(logic [7:0] b);
    send_item(KIND_BYTE, b, 4'($urandom), 16'($urandom));
  endtask

  // Sends the collected frame, optionally its CRC (possibly corrupted), and the end marker.
  task automatic send_frame(bit with_crc, bit corrupt);
    logic [15:0] c;
    c = 16'hFFFF;
    foreach (frame_bytes[i]) begin
      c = crc16_update(c, frame_bytes[i]);
      send_byte(frame_bytes[i]);
    end
    if (with_crc) begin
      if (corrupt) c = c ^ (16'h1 << $urandom_range(15));
      send_byte(c[7:0]);
      send_byte(c[15:8]);
    end
    send_item(KIND_EOF, 8'($urandom), 4'($urandom), 16'($urandom));
    frame_bytes.delete();
  endtask

  // Valid drops right at the accepting edge so the last beat is not taken twice.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] regnum, logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {regnum, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (regnum)
      REG_SLAVE: own_addr = value[7:0];
      REG_RBASE: rd_base = value[15:0];
      default:   wr_base = value[15:0];
    endcase
  endtask

  task automatic push_header(logic [7:0] addr, logic [7:0] func, int start, int qty);
    frame_bytes.push_back(addr);
    frame_bytes.push_back(func);
    frame_bytes.push_back(8'(start >> 8));
    frame_bytes.push_back(8'(start));
    frame_bytes.push_back(8'(qty >> 8));
    frame_bytes.push_back(8'(qty));
  endtask

  // One random transaction, mostly well-formed requests with random content.
  task automatic random_transaction();
    int sel, off, qty, n;
    logic [7:0] fn;
    sel = $urandom_range(99);
    off = $urandom_range(15);
    if (sel < 15) begin
      qty = $urandom_range(16 - off);
      if ($urandom_range(3) == 0) qty = $urandom_range(3);
      push_header(own_addr, FN_READ, (rd_base + off) & 16'hFFFF, qty);
      send_frame(1, 0);
    end else if (sel < 30) begin
      push_header(own_addr, FN_WRITE1, (wr_base + off) & 16'hFFFF, $urandom_range(65535));
      send_frame(1, 0);
    end else if (sel < 45) begin
      qty = $urandom_range(16 - off);
      if (qty > 4 && $urandom_range(2) != 0) qty = $urandom_range(4);
      push_header(own_addr, FN_WRITEN, (wr_base + off) & 16'hFFFF, qty);
      frame_bytes.push_back($urandom_range(3) == 0 ? 8'($urandom) : 8'(qty * 2));
      n = 2 * qty;
      if ($urandom_range(4) == 0 && n > 0) n = $urandom_range(n - 1);
      repeat (n) frame_bytes.push_back(8'($urandom));
      send_frame(1, 0);
    end else if (sel < 52) begin
      // Address or quantity out of range.
      fn = ($urandom_range(2) == 0) ? FN_READ : ($urandom_range(1) ? FN_WRITE1 : FN_WRITEN);
      push_header(own_addr, fn, $urandom_range(65535), $urandom_range(65535));
      send_frame(1, 0);
    end else if (sel < 57) begin
      // Single write in a frame longer than eight bytes.
      push_header(own_addr, FN_WRITE1, (wr_base + off) & 16'hFFFF, $urandom_range(65535));
      repeat ($urandom_range(1, 3)) frame_bytes.push_back(8'($urandom));
      send_frame(1, 0);
    end else if (sel < 62) begin
      do fn = 8'($urandom); while (fn == FN_READ || fn == FN_WRITE1 || fn == FN_WRITEN);
      push_header(own_addr, fn, $urandom_range(65535), $urandom_range(65535));
      send_frame(1, 0);
    end else if (sel < 67) begin
      push_header(own_addr, FN_READ, (rd_base + off) & 16'hFFFF, $urandom_range(16 - off));
      send_frame(1, 1);
    end else if (sel < 71) begin
      push_header(own_addr ^ 8'($urandom_range(1, 255)), FN_READ, rd_base, 1);
      send_frame(1, 0);
    end else if (sel < 75) begin
      repeat ($urandom_range(7)) frame_bytes.push_back(8'($urandom));
      if (frame_bytes.size() > 0) frame_bytes[0] = own_addr;
      send_frame(0, 0);
    end else if (sel < 77) begin
      // Overrun: more bytes than the buffer holds.
      frame_bytes.push_back(own_addr);
      repeat ($urandom_range(64, 70)) frame_bytes.push_back(8'($urandom));
      send_frame(1, 0);
    end else if (sel < 88) begin
      send_item(KIND_SET, 8'($urandom), 4'($urandom), 16'($urandom));
    end else begin
      send_item(KIND_GET, 8'($urandom), 4'($urandom), 16'($urandom));
    end
  endtask

  stim_row_t directed [$] = '{
    '{KIND_GET,  8'h00, 4'd0,  16'h0000, 0, 1, 16'h0000},
    '{KIND_GET,  8'hFF, 4'd15, 16'hFFFF, 0, 1, 16'h0000},
    '{KIND_SET,  8'h00, 4'd3,  16'hFFFF, 0, 0, 16'h0000},
    '{KIND_SET,  8'h00, 4'd15, 16'h1234, 0, 0, 16'h0000},
    '{KIND_BYTE, 8'h01, 4'd0,  16'h0000, 0, 0, 16'h0000},
    '{KIND_BYTE, 8'h03, 4'd0,  16'h0000, 0, 0, 16'h0000},
    '{KIND_BYTE, 8'h00, 4'd0,  16'h0000, 0, 0, 16'h0000},
    '{KIND_BYTE, 8'h03, 4'd0,  16'h0000, 0, 0, 16'h0000},
    '{KIND_BYTE, 8'h00, 4'd0,  16'h0000, 0, 0, 16'h0000},
    '{KIND_BYTE, 8'h01, 4'd0,  16'h0000, 0, 0, 16'h0000},
    '{KIND_EOF,  8'h00, 4'd0,  16'h0000, 1, 0, 16'h0000},
    '{KIND_BYTE, 8'h01, 4'd0,  16'h0000, 0, 0, 16'h0000},
    '{KIND_BYTE, 8'h06, 4'd0,  16'h0000, 0, 0, 16'h0000},
    '{KIND_BYTE, 8'h00, 4'd0,  16'h0000, 0, 0, 16'h0000},
    '{KIND_BYTE, 8'h0F, 4'd0,  16'h0000, 0, 0, 16'h0000},
    '{KIND_BYTE, 8'hAB, 4'd0,  16'h0000, 0, 0, 16'h0000},
    '{KIND_BYTE, 8'hCD, 4'd0,  16'h0000, 0, 0, 16'h0000},
    '{KIND_EOF,  8'h00, 4'd0,  16'h0000, 1, 0, 16'h0000},
    '{KIND_BYTE, 8'h01, 4'd0,  16'h0000, 0, 0, 16'h0000},
    '{KIND_EOF,  8'h00, 4'd0,  16'h0000, 0, 0, 16'h0000},
    '{KIND_GET,  8'h00, 4'd15, 16'h0000, 0, 1, 16'hABCD}
  };

  always @(posedge clk) out_tready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Response checker.
  always @(posedge clk) begin
    resp_beat_t want;
    resp_beat_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tuser, out_tdata[7:0], out_tlast, out_tdata[23:8], out_tdata[24],
              out_tdata[25], out_tdata[29:26]};
      beats_seen++;
      if (out_tlast) replies_seen++;
      if (pending_beats.size() == 0) begin
        $error("unexpected beat %h", got);
        errors++;
      end else begin
        want = pending_beats.pop_front();
        if (got.result_kind !== want.result_kind) begin
          $error("result_kind: expected %h actual %h", want.result_kind, got.result_kind);
          errors++;
        end
        if (got.tx_byte !== want.tx_byte) begin
          $error("tx_byte: expected %h actual %h", want.tx_byte, got.tx_byte);
          errors++;
        end
        if (got.tx_last !== want.tx_last) begin
          $error("tx_last: expected %h actual %h", want.tx_last, got.tx_last);
          errors++;
        end
        if (got.app_value !== want.app_value) begin
          $error("app_value: expected %h actual %h", want.app_value, got.app_value);
          errors++;
        end
        if (got.motor_command !== want.motor_command) begin
          $error("motor_command: expected %h actual %h", want.motor_command,
                 got.motor_command);
          errors++;
        end
        if (got.load_command !== want.load_command) begin
          $error("load_command: expected %h actual %h", want.load_command, got.load_command);
          errors++;
        end
        if (got.command_index !== want.command_index) begin
          $error("command_index: expected %h actual %h", want.command_index,
                 got.command_index);
          errors++;
        end
      end
    end
  end

  initial begin
    logic [15:0] c;
    int phase_start;
    resp_beat_t bt;
    own_addr = 8'd1;
    rd_base = '0;
    wr_base = '0;
    rx_count = 0;
    rx_overrun = 1'b0;
    rx_crc = 16'hFFFF;
    foreach (read_regs[i]) begin
      read_regs[i] = '0;
      hold_regs[i] = '0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at reset configuration; the CRC is inserted before sealed end markers.
    c = 16'hFFFF;
    foreach (directed[r]) begin
      if (directed[r].kind == KIND_EOF && directed[r].seal_crc) begin
        send_byte(c[7:0]);
        send_byte(c[15:8]);
      end
      send_item(directed[r].kind, directed[r].rx_byte, directed[r].reg_index,
                directed[r].reg_value);
      if (directed[r].known) begin
        bt = '0;
        bt.result_kind = 1'b1;
        bt.app_value = directed[r].known_value;
        pending_beats[pending_beats.size() - 1] = bt;
      end
      if (directed[r].kind == KIND_BYTE) c = crc16_update(c, directed[r].rx_byte);
      else if (directed[r].kind == KIND_EOF) c = 16'hFFFF;
    end

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        0: begin
          cfg_write(REG_SLAVE, 32'd247);
          cfg_write(REG_RBASE, 32'd0);
          cfg_write(REG_WBASE, 32'd65535);
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          cfg_write(REG_SLAVE, 32'd1);
          cfg_write(REG_RBASE, 32'd65535);
          cfg_write(REG_WBASE, 32'd0);
          idle_pct = 63;
          stall_pct = 0;
        end
        2: begin
          cfg_write(REG_SLAVE, $urandom_range(1, 247));
          cfg_write(REG_RBASE, 32'd65520);
          cfg_write(REG_WBASE, 32'd65520);
          idle_pct = 0;
          stall_pct = 63;
        end
        default: begin
          cfg_write(REG_SLAVE, $urandom_range(1, 247));
          cfg_write(REG_RBASE, $urandom_range(65535));
          cfg_write(REG_WBASE, $urandom_range(65535));
          idle_pct = 32;
          stall_pct = 32;
        end
      endcase
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) random_transaction();
    end

    drain();
    $display("Sent %0d input beats over four configurations and handshake mixes;",
             items_sent);
    $display("checked %0d output beats in %0d responses.", beats_seen, replies_seen);
    if (errors == 0 && pending_beats.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
